// ----- hw/rtl/tks_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the top-k smallest select block.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int SCORE_W        = 32;
	localparam int LABEL_W        = 32;
	localparam int NRES_W         = 5;
	localparam int DEF_MAX_K      = 16;
	localparam int DEF_LABEL_BITS = 32;
	localparam int DEF_CNT_W      = $clog2(DEF_MAX_K + 1);
	localparam logic [NRES_W-1:0] NRES_RESET = 5'd10;

	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic take_in;
		logic append;
		logic replace;
		logic scan_start;
		logic scan_step;
		logic dec;
		logic mv_rd;
		logic mv_wr;
		logic load_stat;
		logic load_cand;
	} tks_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_drain;
		logic cnt_zero;
		logic cnt_one;
		logic room;
		logic better;
		logic scan_done;
	} tks_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tks_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_if
// Valid/ready channels of the top-k select block: item, result, config.
// ----------------------------------------------------------------------------
interface tks_item_if import tks_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic signed [SCORE_W-1:0] score;
	logic [LABEL_W-1:0]        label;

	modport source (output valid, output opcode, output score, output label, input ready);
	modport sink   (input valid, input opcode, input score, input label, output ready);
endinterface

interface tks_result_if import tks_pkg::*; #(parameter int CNT_W = DEF_CNT_W) ();
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] upper_bound;
	logic [CNT_W-1:0]          held_count;
	logic                      accepted;
	logic signed [SCORE_W-1:0] cand_score;
	logic [LABEL_W-1:0]        cand_label;
	logic                      last;

	modport source (output valid, output upper_bound, output held_count, output accepted,
		output cand_score, output cand_label, output last, input ready);
	modport sink   (input valid, input upper_bound, input held_count, input accepted,
		input cand_score, input cand_label, input last, output ready);
endinterface

interface tks_cfg_if import tks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NRES_W-1:0] n_results;

	modport source (output valid, output n_results, input ready);
	modport sink   (input valid, input n_results, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tks_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tks_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_ctrl
// Sequencer: decides offer/drain handling, runs worst-entry scans and
// drives the result register's valid.
// ----------------------------------------------------------------------------
module tks_ctrl import tks_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire tks_sts_t sts,
	output tks_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_RESULT = 3'd3;
	localparam logic [2:0] S_DEMIT  = 3'd4;
	localparam logic [2:0] S_MVRD   = 3'd5;
	localparam logic [2:0] S_MVWR   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free  = !out_valid_q || out_ready;
	assign item_ready = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.op_drain) begin
					if (sts.room) begin
						cmd.append = 1'b1;
						state_d    = S_RESULT;
					end else if (!sts.cnt_zero && sts.better) begin
						cmd.replace    = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end else begin
						state_d = S_RESULT;
					end
				end else if (sts.cnt_zero) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_DEMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.op_drain ? S_DEMIT : S_RESULT;
				end
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.load_stat = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DEMIT: begin
				if (slot_free) begin
					cmd.load_cand = 1'b1;
					cmd.dec       = 1'b1;
					state_d       = sts.cnt_one ? S_IDLE : S_MVRD;
				end
			end
			S_MVRD: begin
				cmd.mv_rd = 1'b1;
				state_d   = S_MVWR;
			end
			S_MVWR: begin
				cmd.mv_wr      = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_stat || cmd.load_cand) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tks_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_dp
// Datapath: candidate RAM, held count, cached worst pair, scan pipeline,
// k register and the result payload register.
// ----------------------------------------------------------------------------
module tks_dp import tks_pkg::*; #(
	parameter int MAX_K      = DEF_MAX_K,
	parameter int LABEL_BITS = DEF_LABEL_BITS,
	localparam int IDX_W     = (MAX_K > 1) ? $clog2(MAX_K) : 1,
	localparam int CNT_W     = $clog2(MAX_K + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tks_cmd_t                  cmd,
	output tks_sts_t                       sts,
	input  wire logic                      in_opcode,
	input  wire logic signed [SCORE_W-1:0] in_score,
	input  wire logic [LABEL_W-1:0]        in_label,
	input  wire logic                      cfg_we,
	input  wire logic [NRES_W-1:0]         cfg_nres,
	output logic signed [SCORE_W-1:0]      upper_bound,
	output logic [CNT_W-1:0]               held_count,
	output logic                           accepted,
	output logic signed [SCORE_W-1:0]      cand_score,
	output logic [LABEL_W-1:0]             cand_label,
	output logic                           last
);

	localparam int ENT_W = SCORE_W + LABEL_BITS;
	localparam int LIM_W = (NRES_W > CNT_W) ? NRES_W : CNT_W;

	// latched item
	logic                      op_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [LABEL_BITS-1:0]     label_q;
	logic                      acc_q;

	logic [NRES_W-1:0]         nres_q;
	logic [CNT_W-1:0]          count_q;

	// cached worst held pair
	logic signed [SCORE_W-1:0] wscore_q;
	logic [LABEL_BITS-1:0]     wlabel_q;
	logic [IDX_W-1:0]          widx_q;

	// scan pipeline
	logic [CNT_W-1:0]          sidx_q;
	logic                      first_q;
	logic                      rd_pend_s1;
	logic [IDX_W-1:0]          rd_idx_s1;

	logic                      issue;
	logic                      we;
	logic [IDX_W-1:0]          waddr;
	logic [IDX_W-1:0]          raddr;
	logic [ENT_W-1:0]          wdata;
	logic [ENT_W-1:0]          rdata;
	logic signed [SCORE_W-1:0] rd_score;
	logic [LABEL_BITS-1:0]     rd_label;
	logic                      rd_worse;
	logic                      new_worse;

	logic [LABEL_BITS+LABEL_W-1:0] lab_in_ext;
	logic [LABEL_BITS+LABEL_W-1:0] lab_out_ext;
	logic [LIM_W-1:0]              lim;
	logic [LIM_W-1:0]              nres_ext;
	logic [LIM_W-1:0]              cnt_ext;

	assign lab_in_ext  = {{LABEL_BITS{1'b0}}, in_label};
	assign lab_out_ext = {{LABEL_W{1'b0}}, wlabel_q};

	// k clamped to 1..MAX_K
	assign nres_ext = LIM_W'(nres_q);
	assign cnt_ext  = LIM_W'(count_q);
	always_comb begin
		if (nres_q == '0) begin
			lim = LIM_W'(1);
		end else if (nres_ext > LIM_W'(MAX_K)) begin
			lim = LIM_W'(MAX_K);
		end else begin
			lim = nres_ext;
		end
	end

	assign rd_score  = $signed(rdata[SCORE_W-1:0]);
	assign rd_label  = rdata[ENT_W-1:SCORE_W];
	assign rd_worse  = (rd_score > wscore_q) || ((rd_score == wscore_q) && (rd_label > wlabel_q));
	assign new_worse = (score_q > wscore_q) || ((score_q == wscore_q) && (label_q > wlabel_q));

	assign issue = cmd.scan_step && (sidx_q < count_q);
	assign we    = cmd.append || cmd.replace || cmd.mv_wr;
	assign waddr = cmd.append ? count_q[IDX_W-1:0] : widx_q;
	assign wdata = cmd.mv_wr ? rdata : {label_q, score_q};
	assign raddr = cmd.mv_rd ? count_q[IDX_W-1:0] : sidx_q[IDX_W-1:0];

	tks_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_K)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		sts           = '0;
		sts.op_drain  = (op_q == OP_DRAIN);
		sts.cnt_zero  = (count_q == '0);
		sts.cnt_one   = (count_q == CNT_W'(1));
		sts.room      = (cnt_ext < lim);
		sts.better    = (score_q < wscore_q);
		sts.scan_done = (sidx_q == count_q) && !rd_pend_s1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nres_q     <= NRES_RESET;
			count_q    <= '0;
			sidx_q     <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				nres_q <= cfg_nres;
			end
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.scan_start) begin
				sidx_q <= '0;
			end else if (issue) begin
				sidx_q <= sidx_q + CNT_W'(1);
			end
			rd_pend_s1 <= issue;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q    <= in_opcode;
			score_q <= in_score;
			label_q <= lab_in_ext[LABEL_BITS-1:0];
			acc_q   <= 1'b0;
		end else if (cmd.append || cmd.replace) begin
			acc_q <= 1'b1;
		end

		rd_idx_s1 <= sidx_q[IDX_W-1:0];

		if (cmd.append) begin
			if (count_q == '0 || new_worse) begin
				wscore_q <= score_q;
				wlabel_q <= label_q;
				widx_q   <= count_q[IDX_W-1:0];
			end
		end else if (rd_pend_s1) begin
			if (first_q || rd_worse) begin
				wscore_q <= rd_score;
				wlabel_q <= rd_label;
				widx_q   <= rd_idx_s1;
			end
		end

		if (cmd.scan_start) begin
			first_q <= 1'b1;
		end else if (rd_pend_s1) begin
			first_q <= 1'b0;
		end

		if (cmd.load_stat) begin
			upper_bound <= (count_q == '0) ? '0 : wscore_q;
			held_count  <= count_q;
			accepted    <= acc_q;
			cand_score  <= '0;
			cand_label  <= '0;
			last        <= 1'b1;
		end else if (cmd.load_cand) begin
			upper_bound <= '0;
			held_count  <= '0;
			accepted    <= 1'b0;
			cand_score  <= wscore_q;
			cand_label  <= lab_out_ext[LABEL_W-1:0];
			last        <= (count_q == CNT_W'(1));
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/top_k_smallest_select.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_smallest_select
// Streaming top-k selector keeping the k smallest (score, label) pairs.
// ----------------------------------------------------------------------------
// Usage: offer items (opcode 0) with a signed Q16.16 score and a label; the
// block keeps the k = n_results smallest pairs (k clamped to 1..MAX_K, ties
// broken so the larger label is worse) and answers every offer with one
// result: the worst score held (0 when empty), the held count and whether
// the item went in. A drain (opcode 1) returns the held pairs worst first,
// one result per pair with last on the final one, and empties the store; a
// drain of an empty store returns a single all-zero result with last set.
// Timing: one item is worked on at a time; item.ready is high only while the
// block is idle. After an offer that replaces the worst pair, the worst pair
// is found again by a scan that reads the one-read-port candidate RAM one
// entry per cycle. A drain likewise rescans after each emitted pair but the
// last. The result sits in an output register, so a stalled result channel
// only delays the next transaction. Write n_results only while idle;
// cfg.ready is always high.
// ----------------------------------------------------------------------------
module top_k_smallest_select import tks_pkg::*; #(
	parameter int MAX_K      = DEF_MAX_K,
	parameter int LABEL_BITS = DEF_LABEL_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tks_item_if.sink     item,
	tks_result_if.source result,
	tks_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(MAX_K + 1);

	tks_cmd_t cmd;
	tks_sts_t sts;

	logic                      item_ready;
	logic                      out_valid;
	logic signed [SCORE_W-1:0] upper_bound;
	logic [CNT_W-1:0]          held_count;
	logic                      accepted;
	logic signed [SCORE_W-1:0] cand_score;
	logic [LABEL_W-1:0]        cand_label;
	logic                      last;

	// config is always accepted; the contract says it only moves while idle
	assign cfg.ready = 1'b1;

	assign item.ready         = item_ready;
	assign result.valid       = out_valid;
	assign result.upper_bound = upper_bound;
	assign result.held_count  = held_count;
	assign result.accepted    = accepted;
	assign result.cand_score  = cand_score;
	assign result.cand_label  = cand_label;
	assign result.last        = last;

	// sequencer
	tks_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.out_valid  (out_valid),
		.out_ready  (result.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// storage, worst tracking and result payload
	tks_dp #(
		.MAX_K      (MAX_K),
		.LABEL_BITS (LABEL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_opcode   (item.opcode),
		.in_score    (item.score),
		.in_label    (item.label),
		.cfg_we      (cfg.valid),
		.cfg_nres    (cfg.n_results),
		.upper_bound (upper_bound),
		.held_count  (held_count),
		.accepted    (accepted),
		.cand_score  (cand_score),
		.cand_label  (cand_label),
		.last        (last)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/tks_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks for the top-k select block, bound to the top level.
// ----------------------------------------------------------------------------
module tks_checker import tks_pkg::*; #(
	parameter int MAX_K  = DEF_MAX_K,
	localparam int CNT_W = $clog2(MAX_K + 1)
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      item_valid,
	input wire logic                      item_ready,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic signed [SCORE_W-1:0] upper_bound,
	input wire logic [CNT_W-1:0]          held_count,
	input wire logic                      accepted,
	input wire logic signed [SCORE_W-1:0] cand_score,
	input wire logic [LABEL_W-1:0]        cand_label,
	input wire logic                      last
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(cand_score) && $stable(cand_label)
			&& $stable(last) && $stable(held_count) && $stable(upper_bound)
			&& $stable(accepted))
		else $error("result changed while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> held_count <= CNT_W'(MAX_K))
		else $error("held count above MAX_K");

	// an offer result carries no candidate and closes its transaction
	a_acc_offer: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && accepted |-> last && cand_score == '0 && cand_label == '0)
		else $error("accepted flag on a drain result");

	// mid-drain the block takes no new item
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> !item_ready)
		else $error("item ready during a drain");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken before the first completed");

endmodule

bind top_k_smallest_select tks_checker #(.MAX_K(MAX_K)) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.upper_bound (result.upper_bound),
	.held_count  (result.held_count),
	.accepted    (result.accepted),
	.cand_score  (result.cand_score),
	.cand_label  (result.cand_label),
	.last        (result.last)
);
`default_nettype wire

// ----- bench/tb_top_k_smallest_select.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_smallest_select
// Self-checking bench for the streaming top-k smallest select block.
// ----------------------------------------------------------------------------
// A short directed table covers edge scores, ties on score, k clamping at
// both ends, shrinking k below the held count and empty drains. Random phases
// follow: each one writes a new k, offers a run of scored items and mostly
// ends in a drain. Every result transaction is compared field by field with
// its typed row or an in-bench model of the store. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top_k_smallest_select;
	import tks_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 90;
	// Longest quiet stretch of a correct run: longest sender gap + longest
	// result stall + one rescan of a full store, many times over.
	localparam int STALL_LIMIT  = 4000;
	// A full drain rescans per pair, so allow a generous tail after the end.
	localparam int DRAIN_TAIL   = 40;
	localparam int HEAP_DEPTH   = DEF_MAX_K;
	localparam int CNT_W        = DEF_CNT_W;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic [LABEL_W-1:0]        label_t;
	typedef logic [CNT_W-1:0]          count_t;
	typedef logic [NRES_W-1:0]         kval_t;

	// one result transaction as it leaves the block
	typedef struct {
		score_t upper_bound;
		count_t held_count;
		logic   accepted;
		score_t cand_score;
		label_t cand_label;
		logic   last;
	} topk_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// directed row: either an item or a k write; typed rows carry their result
	typedef struct {
		row_kind_t kind;
		logic      opcode;
		score_t    score;
		label_t    label;
		kval_t     k_value;
		bit        typed;
		score_t    want_bound;
		count_t    want_count;
		logic      want_acc;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tks_item_if   item_ch ();
	tks_result_if result_ch ();
	tks_cfg_if    cfg_ch ();

	top_k_smallest_select dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Heap model: held pairs, held count, worst held score and raw k register.
	// ------------------------------------------------------------------------
	score_t       heap_score [HEAP_DEPTH];
	label_t       heap_label [HEAP_DEPTH];
	int unsigned  heap_n;
	score_t       heap_bound;
	kval_t        k_reg;

	topk_result_t expected_q [$];
	stim_row_t    dir_rows [$];
	int unsigned  fail_count;
	int unsigned  burst_left;

	// pair order: score first, larger label is worse on a tie
	function automatic bit pair_worse(score_t sa, label_t la, score_t sb, label_t lb);
		return (sa > sb) || (sa == sb && la > lb);
	endfunction

	function automatic int unsigned worst_slot();
		int unsigned w;
		w = 0;
		for (int unsigned i = 1; i < heap_n; i++) begin
			if (pair_worse(heap_score[i], heap_label[i], heap_score[w], heap_label[w]))
				w = i;
		end
		return w;
	endfunction

	// k of 0 behaves as 1, anything past the store depth saturates
	function automatic int unsigned clamped_k();
		if (k_reg == '0)
			return 1;
		if (k_reg > HEAP_DEPTH)
			return HEAP_DEPTH;
		return int'(k_reg);
	endfunction

	// Advance the model by one accepted item; queue its results when asked.
	task automatic predict_item(input logic op, input score_t s, input label_t l,
		input bit record);
		topk_result_t r;
		int unsigned  w;
		logic         acc;
		r = '{default: '0};
		r.last = 1'b1;
		acc = 1'b0;
		if (op == OP_OFFER) begin
			if (heap_n < clamped_k()) begin
				heap_score[heap_n] = s;
				heap_label[heap_n] = l;
				heap_n++;
				acc = 1'b1;
			end else if (heap_n > 0 && s < heap_bound) begin
				// full (or over-full after k shrank): replace the worst pair
				w = worst_slot();
				heap_score[w] = s;
				heap_label[w] = l;
				acc = 1'b1;
			end
			if (heap_n > 0)
				heap_bound = heap_score[worst_slot()];
			r.upper_bound = heap_bound;
			r.held_count  = count_t'(heap_n);
			r.accepted    = acc;
			if (record)
				expected_q.push_back(r);
		end else if (heap_n == 0) begin
			// empty drain: a single all-zero result with last set
			heap_bound = '0;
			if (record)
				expected_q.push_back(r);
		end else begin
			// drain worst first; the tail entry fills the hole each time
			while (heap_n > 0) begin
				w = worst_slot();
				r.cand_score = heap_score[w];
				r.cand_label = heap_label[w];
				r.last       = (heap_n == 1);
				if (record)
					expected_q.push_back(r);
				heap_n--;
				heap_score[w] = heap_score[heap_n];
				heap_label[w] = heap_label[heap_n];
			end
			heap_bound = '0;
		end
	endtask

	// Sender gap: mostly none, some short, a few long, plus gap-free bursts.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			burst_left = $urandom_range(8, 20);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_row(input row_kind_t kind, input logic op, input score_t s,
		input label_t l, input kval_t kv, input bit typed, input score_t wb,
		input count_t wc, input logic wa);
		stim_row_t r;
		r.kind       = kind;
		r.opcode     = op;
		r.score      = s;
		r.label      = l;
		r.k_value    = kv;
		r.typed      = typed;
		r.want_bound = wb;
		r.want_count = wc;
		r.want_acc   = wa;
		dir_rows.push_back(r);
	endtask

	// Drive one item transaction. Valid stays high after acceptance so that
	// back-to-back items need no extra edge; whoever waits lowers it.
	task automatic send_item(input logic op, input score_t s, input label_t l,
		input bit typed, input topk_result_t want);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid  <= 1'b1;
		item_ch.opcode <= op;
		item_ch.score  <= s;
		item_ch.label  <= l;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_item(op, s, l, !typed);
		if (typed)
			expected_q.push_back(want);
	endtask

	// Hold off the sender until every expected result is in and the block
	// is back to idle (item.ready only rises when idle).
	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0 || !item_ch.ready)
			@(posedge clk);
	endtask

	// k is only written while idle
	task automatic write_k(input kval_t kv);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.n_results <= kv;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		k_reg = kv;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Result sink: random stalls, mostly short, a few long, with calm spells.
	// ------------------------------------------------------------------------
	initial begin : ready_gen
		int unsigned stall_left;
		int unsigned calm_left;
		int unsigned roll;
		stall_left      = 0;
		calm_left       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 4)
						calm_left = $urandom_range(20, 80);
					else if (roll < 30)
						stall_left = $urandom_range(1, 3);
					else if (roll < 34)
						stall_left = $urandom_range(20, 60);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: each result transaction against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		topk_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected");
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (result_ch.upper_bound !== want.upper_bound) begin
					$error("upper_bound: expected %0d, got %0d",
						want.upper_bound, result_ch.upper_bound);
					fail_count++;
				end
				if (result_ch.held_count !== want.held_count) begin
					$error("held_count: expected %0d, got %0d",
						want.held_count, result_ch.held_count);
					fail_count++;
				end
				if (result_ch.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d",
						want.accepted, result_ch.accepted);
					fail_count++;
				end
				if (result_ch.cand_score !== want.cand_score) begin
					$error("cand_score: expected %0d, got %0d",
						want.cand_score, result_ch.cand_score);
					fail_count++;
				end
				if (result_ch.cand_label !== want.cand_label) begin
					$error("cand_label: expected %0h, got %0h",
						want.cand_label, result_ch.cand_label);
					fail_count++;
				end
				if (result_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result_ch.last);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too many cycles in a row without any transaction ends the run.
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		stim_row_t    row;
		topk_result_t want;
		int unsigned  sent;
		int unsigned  phase_len;
		int unsigned  roll;
		logic         op;
		score_t       s;
		label_t       l;
		kval_t        kv;

		// every input known from time zero
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.opcode   = OP_OFFER;
		item_ch.score    = '0;
		item_ch.label    = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.n_results = NRES_RESET;

		heap_n     = 0;
		heap_bound = '0;
		k_reg      = NRES_RESET;
		fail_count = 0;
		burst_left = 0;
		want       = '{default: '0};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. k is 10 out of reset. Typed rows carry bound,
		// count and accepted; their candidate fields are 0 and last is 1.
		// drain right after reset: nothing held
		add_row(ROW_ITEM, OP_DRAIN, '0, '0, '0, 1'b1, '0, '0, 1'b0);
		// score extremes, label extremes
		add_row(ROW_ITEM, OP_OFFER, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, '0, 1'b1,
			32'sh7FFF_FFFF, count_t'(1), 1'b1);
		add_row(ROW_ITEM, OP_OFFER, 32'sh8000_0000, 32'h0000_0000, '0, 1'b1,
			32'sh7FFF_FFFF, count_t'(2), 1'b1);
		// same top score, smaller label: ranks better than the first pair
		add_row(ROW_ITEM, OP_OFFER, 32'sh7FFF_FFFF, 32'h0000_0000, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0000_0000, 32'h0000_0005, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_DRAIN, '0, '0, '0, 1'b0, '0, '0, 1'b0);
		// k of 0 acts as 1
		add_row(ROW_CFG, OP_OFFER, '0, '0, 5'd0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0064_0000, 32'h1, '0, 1'b1, 32'sh0064_0000,
			count_t'(1), 1'b1);
		// equal to the bound: skipped
		add_row(ROW_ITEM, OP_OFFER, 32'sh0064_0000, 32'h0, '0, 1'b1, 32'sh0064_0000,
			count_t'(1), 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0032_0000, 32'h9, '0, 1'b1, 32'sh0032_0000,
			count_t'(1), 1'b1);
		add_row(ROW_ITEM, OP_OFFER, 32'sh8000_0000, 32'hFFFF_FFFF, '0, 1'b1,
			32'sh8000_0000, count_t'(1), 1'b1);
		// k of 31 saturates to the store depth
		add_row(ROW_CFG, OP_OFFER, '0, '0, 5'd31, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'shFFFF_FFFF, 32'h3, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0001_0000, 32'h7, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0001_0000, 32'h2, '0, 1'b0, '0, '0, 1'b0);
		// k drops below the four pairs held: store keeps them, only replaces
		add_row(ROW_CFG, OP_OFFER, '0, '0, 5'd2, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0000_8000, 32'h8, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh7FFF_FFFF, 32'h1, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_CFG, OP_OFFER, '0, '0, 5'd16, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_OFFER, 32'sh0000_0000, 32'h0, '0, 1'b0, '0, '0, 1'b0);
		add_row(ROW_ITEM, OP_DRAIN, '0, '0, '0, 1'b0, '0, '0, 1'b0);
		// second drain in a row finds the store empty
		add_row(ROW_ITEM, OP_DRAIN, '0, '0, '0, 1'b1, '0, '0, 1'b0);
		add_row(ROW_CFG, OP_OFFER, '0, '0, NRES_RESET, 1'b0, '0, '0, 1'b0);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG) begin
				write_k(row.k_value);
			end else begin
				want             = '{default: '0};
				want.upper_bound = row.want_bound;
				want.held_count  = row.want_count;
				want.accepted    = row.want_acc;
				want.last        = 1'b1;
				send_item(row.opcode, row.score, row.label, row.typed, want);
			end
		end

		// Random phases: new k (extremes often), a run of offers with the
		// odd drain inside, then usually a drain. Phases that skip the drain
		// leave pairs behind, so the next k may land below the held count.
		// Each k write waits for the block to go idle first.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 9);
			case (roll)
				0: kv = 5'd0;
				1: kv = 5'd1;
				2: kv = 5'd16;
				3: kv = kval_t'($urandom_range(17, 31));
				default: kv = kval_t'($urandom_range(1, 16));
			endcase
			write_k(kv);

			phase_len = $urandom_range(2, 24);
			if (phase_len > RANDOM_ITEMS - sent)
				phase_len = RANDOM_ITEMS - sent;
			repeat (phase_len) begin
				op = ($urandom_range(0, 19) == 0) ? OP_DRAIN : OP_OFFER;
				roll = $urandom_range(0, 9);
				if (roll < 4)
					s = score_t'($urandom);
				else if (roll < 7)
					s = score_t'((int'($urandom_range(0, 8)) - 4) * 65536);  // ties
				else if (roll < 8)
					s = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
				else
					// at or just under the current bound: replacements and skips
					s = heap_bound - score_t'($urandom_range(0, 3) * 16384);
				if ($urandom_range(0, 2) == 0)
					l = label_t'($urandom_range(0, 3));
				else
					l = label_t'($urandom);
				send_item(op, s, l, 1'b0, want);
				sent++;
			end
			if ($urandom_range(0, 9) < 7) begin
				send_item(OP_DRAIN, score_t'($urandom), label_t'($urandom), 1'b0, want);
				sent++;
			end
		end

		// wait out the last results, then a tail for any straggler
		wait_idle();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tks_pkg.sv
hw/rtl/tks_if.sv
hw/rtl/tks_ram.sv
hw/rtl/tks_ctrl.sv
hw/rtl/tks_dp.sv
hw/rtl/top_k_smallest_select.sv
hw/rtl/tks_checker.sv
bench/tb_top_k_smallest_select.sv
